/* src/bfc_pkg.sv */
// ---------------------------------------------------------------------------
// bfc_pkg
// Shared constants, plane register layout and helpers for the box frustum
// cull pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

    // plane set and register layout
    localparam int NUM_PLANES      = 6;
    localparam int NUM_AXES        = 3;
    localparam int PLANE_W         = 64;
    localparam int FIELD_W         = 16;
    localparam int FRAC_BITS       = 14;
    localparam int CFG_IDX_W       = 3;
    localparam int COORD_WIDTH_DEF = 16;

    // axis numbering used by the per-plane arrays
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // one plane register: a in 15:0, b in 31:16, c in 47:32, d in 63:48
    typedef struct packed {
        logic signed [FIELD_W-1:0] d;
        logic signed [FIELD_W-1:0] c;
        logic signed [FIELD_W-1:0] b;
        logic signed [FIELD_W-1:0] a;
    } t_plane;

    typedef t_plane [NUM_PLANES-1:0] t_plane_set;

    // normal component of a plane along one axis
    function automatic logic signed [FIELD_W-1:0] plane_coef(input t_plane p, input int axis);
        logic signed [FIELD_W-1:0] coef;
        case (axis)
            AXIS_X:  coef = p.a;
            AXIS_Y:  coef = p.b;
            default: coef = p.c;
        endcase
        return coef;
    endfunction

endpackage

`default_nettype wire

/* src/bfc_box_if.sv */
// ---------------------------------------------------------------------------
// bfc_box_if
// Request channel carrying one axis-aligned box: centre and half extents.
// ---------------------------------------------------------------------------
`default_nettype none

interface bfc_box_if #(
    parameter int CoordWidth = bfc_pkg::COORD_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [CoordWidth-1:0] center_x;
    logic signed [CoordWidth-1:0] center_y;
    logic signed [CoordWidth-1:0] center_z;
    logic        [CoordWidth-2:0] half_x;
    logic        [CoordWidth-2:0] half_y;
    logic        [CoordWidth-2:0] half_z;

    modport source (
        output valid, center_x, center_y, center_z, half_x, half_y, half_z,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, center_z, half_x, half_y, half_z,
        output ready
    );
endinterface

`default_nettype wire

/* src/bfc_vis_if.sv */
// ---------------------------------------------------------------------------
// bfc_vis_if
// Result channel carrying the visibility flag of one box.
// ---------------------------------------------------------------------------
`default_nettype none

interface bfc_vis_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (
        output valid, visible,
        input  ready
    );

    modport sink (
        input  valid, visible,
        output ready
    );
endinterface

`default_nettype wire

/* src/bfc_vertex_sel.sv */
// ---------------------------------------------------------------------------
// bfc_vertex_sel
// Stage 1: per plane, picks the box corner farthest along the plane normal
// (centre plus or minus half extent by the sign of each normal component).
// ---------------------------------------------------------------------------
`default_nettype none

module bfc_vertex_sel #(
    parameter int CoordWidth = bfc_pkg::COORD_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire bfc_pkg::t_plane_set     i_planes,
    bfc_box_if.sink                      i_box,
    input  wire                          i_ready,
    output logic                         o_valid,
    output logic signed [CoordWidth:0]   o_vert [bfc_pkg::NUM_PLANES][bfc_pkg::NUM_AXES]
);

    localparam int VW = CoordWidth + 1;

    logic                  r_valid;
    logic signed [VW-1:0]  r_vert [bfc_pkg::NUM_PLANES][bfc_pkg::NUM_AXES];
    logic signed [VW-1:0]  n_vert [bfc_pkg::NUM_PLANES][bfc_pkg::NUM_AXES];
    logic signed [VW-1:0]  ctr    [bfc_pkg::NUM_AXES];
    logic signed [VW-1:0]  half   [bfc_pkg::NUM_AXES];
    logic                  take;

    // stage can load when empty or when its contents move on
    assign i_box.ready = !r_valid || i_ready;
    assign take        = i_box.valid && i_box.ready;

    // widen centre (signed) and half extent (unsigned) to vertex width
    always_comb begin
        ctr[bfc_pkg::AXIS_X]  = VW'(i_box.center_x);
        ctr[bfc_pkg::AXIS_Y]  = VW'(i_box.center_y);
        ctr[bfc_pkg::AXIS_Z]  = VW'(i_box.center_z);
        half[bfc_pkg::AXIS_X] = $signed({2'b00, i_box.half_x});
        half[bfc_pkg::AXIS_Y] = $signed({2'b00, i_box.half_y});
        half[bfc_pkg::AXIS_Z] = $signed({2'b00, i_box.half_z});
    end

    // farthest corner along the normal: positive component takes the plus side
    always_comb begin
        for (int p = 0; p < bfc_pkg::NUM_PLANES; p++) begin
            for (int k = 0; k < bfc_pkg::NUM_AXES; k++) begin
                if (bfc_pkg::plane_coef(i_planes[p], k) < 0) begin
                    n_vert[p][k] = ctr[k] - half[k];
                end else begin
                    n_vert[p][k] = ctr[k] + half[k];
                end
            end
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_box.ready) begin
            r_valid <= i_box.valid;
        end
        if (take) begin
            r_vert <= n_vert;
        end
    end

    assign o_valid = r_valid;
    assign o_vert  = r_vert;

endmodule

`default_nettype wire

/* src/bfc_plane_mul.sv */
// ---------------------------------------------------------------------------
// bfc_plane_mul
// Stage 2: multiplies each selected corner coordinate by its Q2.14 normal
// component, eighteen products per box.
// ---------------------------------------------------------------------------
`default_nettype none

module bfc_plane_mul #(
    parameter int CoordWidth = bfc_pkg::COORD_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire bfc_pkg::t_plane_set     i_planes,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire signed [CoordWidth:0]    i_vert [bfc_pkg::NUM_PLANES][bfc_pkg::NUM_AXES],
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [CoordWidth+bfc_pkg::FIELD_W:0]
                                         o_prod [bfc_pkg::NUM_PLANES][bfc_pkg::NUM_AXES]
);

    localparam int PW = CoordWidth + bfc_pkg::FIELD_W + 1;

    logic                 r_valid;
    logic signed [PW-1:0] r_prod [bfc_pkg::NUM_PLANES][bfc_pkg::NUM_AXES];
    logic signed [PW-1:0] n_prod [bfc_pkg::NUM_PLANES][bfc_pkg::NUM_AXES];

    assign o_ready = !r_valid || i_ready;

    // product of normal component and corner coordinate, exact at PW bits
    always_comb begin
        for (int p = 0; p < bfc_pkg::NUM_PLANES; p++) begin
            for (int k = 0; k < bfc_pkg::NUM_AXES; k++) begin
                n_prod[p][k] = PW'(bfc_pkg::plane_coef(i_planes[p], k)) * PW'(i_vert[p][k]);
            end
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

/* src/bfc_plane_sum.sv */
// ---------------------------------------------------------------------------
// bfc_plane_sum
// Stages 3 and 4: sums the three products and the scaled offset per plane,
// keeps the sign as a reject flag, then reduces the six flags into the
// registered visibility result.
// ---------------------------------------------------------------------------
`default_nettype none

module bfc_plane_sum #(
    parameter int CoordWidth = bfc_pkg::COORD_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire bfc_pkg::t_plane_set     i_planes,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire signed [CoordWidth+bfc_pkg::FIELD_W:0]
                                         i_prod [bfc_pkg::NUM_PLANES][bfc_pkg::NUM_AXES],
    bfc_vis_if.source                    o_vis
);

    localparam int SW = CoordWidth + bfc_pkg::FIELD_W + 3;

    logic                             r_rej_valid;
    logic [bfc_pkg::NUM_PLANES-1:0]   r_reject;
    logic [bfc_pkg::NUM_PLANES-1:0]   n_reject;
    logic signed [SW-1:0]             plane_sum [bfc_pkg::NUM_PLANES];
    logic                             r_out_valid;
    logic                             r_visible;
    logic                             out_ready;

    // ready chain through the two stages
    assign out_ready = !r_out_valid || o_vis.ready;
    assign o_ready   = !r_rej_valid || out_ready;

    // plane value at the farthest corner; negative means the whole box is outside
    always_comb begin
        for (int p = 0; p < bfc_pkg::NUM_PLANES; p++) begin
            plane_sum[p] = SW'(i_prod[p][bfc_pkg::AXIS_X])
                         + SW'(i_prod[p][bfc_pkg::AXIS_Y])
                         + SW'(i_prod[p][bfc_pkg::AXIS_Z])
                         + (SW'(i_planes[p].d) <<< bfc_pkg::FRAC_BITS);
            n_reject[p]  = plane_sum[p][SW-1];
        end
    end

    // reject flag stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rej_valid <= 1'b0;
        end else if (o_ready) begin
            r_rej_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_reject <= n_reject;
        end
    end

    // output register: visible unless some plane rejects
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_rej_valid;
        end
        if (r_rej_valid && out_ready) begin
            r_visible <= ~|r_reject;
        end
    end

    assign o_vis.valid   = r_out_valid;
    assign o_vis.visible = r_visible;

endmodule

`default_nettype wire

/* src/box_frustum_cull_top.sv */
// ---------------------------------------------------------------------------
// box_frustum_cull_top
// Visibility test of axis-aligned boxes against six frustum planes.
//
// i_box carries one box per request: signed centre and unsigned half
// extents. o_vis returns one visible flag per box, in order: 0 when the
// box lies fully on the negative side of any plane, else 1.
// Planes are written on the plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_data), index 0..5 = near, far, left, right, top, bottom; other
// indexes are ignored. Write planes only while no boxes are in flight.
// Each box passes four register stages (corner select, multiply, plane
// sum, output) on its way to o_vis. Throughput is one box per cycle while
// o_vis takes results, set by the eighteen multipliers of the multiply
// stage working in parallel.
// When o_vis stalls, each stage holds its request and takes a new one
// only when empty or moving on, so bubbles are squeezed out and up to
// four boxes are held before i_box.ready drops.
// Reset clears all stage valid bits and sets every plane to zero; an
// all-zero plane never culls.
// ---------------------------------------------------------------------------
`default_nettype none

module box_frustum_cull_top #(
    parameter int COORD_WIDTH = bfc_pkg::COORD_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [bfc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [bfc_pkg::PLANE_W-1:0]       i_cfg_data,
    bfc_box_if.sink                          i_box,
    bfc_vis_if.source                        o_vis
);

    localparam int VW = COORD_WIDTH + 1;
    localparam int PW = COORD_WIDTH + bfc_pkg::FIELD_W + 1;

    bfc_pkg::t_plane_set   r_planes;
    logic                  w_sel_valid;
    logic                  w_mul_ready;
    logic                  w_mul_valid;
    logic                  w_sum_ready;
    logic signed [VW-1:0]  w_vert [bfc_pkg::NUM_PLANES][bfc_pkg::NUM_AXES];
    logic signed [PW-1:0]  w_prod [bfc_pkg::NUM_PLANES][bfc_pkg::NUM_AXES];

    // plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else if (i_cfg_we && (i_cfg_idx < bfc_pkg::CFG_IDX_W'(bfc_pkg::NUM_PLANES))) begin
            r_planes[i_cfg_idx] <= i_cfg_data;
        end
    end

    // corner select stage
    bfc_vertex_sel #(
        .CoordWidth (COORD_WIDTH)
    ) u_vertex_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_planes (r_planes),
        .i_box    (i_box),
        .i_ready  (w_mul_ready),
        .o_valid  (w_sel_valid),
        .o_vert   (w_vert)
    );

    // multiply stage
    bfc_plane_mul #(
        .CoordWidth (COORD_WIDTH)
    ) u_plane_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_planes (r_planes),
        .i_valid  (w_sel_valid),
        .o_ready  (w_mul_ready),
        .i_vert   (w_vert),
        .o_valid  (w_mul_valid),
        .i_ready  (w_sum_ready),
        .o_prod   (w_prod)
    );

    // plane sum and output stages
    bfc_plane_sum #(
        .CoordWidth (COORD_WIDTH)
    ) u_plane_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_planes (r_planes),
        .i_valid  (w_mul_valid),
        .o_ready  (w_sum_ready),
        .i_prod   (w_prod),
        .o_vis    (o_vis)
    );

    // a fresh result follows a product set held earlier in the multiply stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_vis.valid) |-> $past(w_mul_valid, 2))
        else $error("result appeared without a request in the multiply stage");

    // write to a valid plane index lands in that plane
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx < bfc_pkg::CFG_IDX_W'(bfc_pkg::NUM_PLANES)))
        |=> (r_planes[$past(i_cfg_idx)] == $past(i_cfg_data)))
        else $error("plane register write lost");

    // write beyond the plane list changes nothing
    a_cfg_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx >= bfc_pkg::CFG_IDX_W'(bfc_pkg::NUM_PLANES)))
        |=> $stable(r_planes))
        else $error("out of range write altered a plane");

endmodule

`default_nettype wire

/* tb/box_frustum_cull_top_tb.sv */
// ---------------------------------------------------------------------------
// box_frustum_cull_top_tb
// Self-checking bench for the box frustum cull pipeline. Boxes are streamed
// into the request channel with random gaps on both sides. Each accepted
// box is scored against a local six-plane corner test, and the returned
// visibility flags are compared in order. The plane registers are reloaded
// between phases: reset zeros, an axis-aligned cube, extreme and random
// plane sets.
// ---------------------------------------------------------------------------

module box_frustum_cull_top_tb;

    localparam int COORD_W     = bfc_pkg::COORD_WIDTH_DEF;
    localparam int HALF_W      = COORD_W - 1;
    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 8;
    localparam int N_PHASES    = 7;
    localparam int PHASE_BOXES = 200;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 12;
    localparam int MAX_REPORTS = 10;
    localparam int SND_IDLE_A  = 23;
    localparam int RCV_IDLE_A  = 46;
    localparam int Q_ONE       = 1 << bfc_pkg::FRAC_BITS;

    // plane register indexes
    typedef enum int {
        REG_NEAR,
        REG_FAR,
        REG_LEFT,
        REG_RIGHT,
        REG_TOP,
        REG_BOTTOM
    } t_plane_reg;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic        [HALF_W-1:0]  hx;
        logic        [HALF_W-1:0]  hy;
        logic        [HALF_W-1:0]  hz;
    } t_box;

    typedef struct {
        t_box b;
        bit   vis;
    } t_vis_entry;

    // plane copy, in-order visibility flags and mismatch accounting
    class t_cull_scoreboard;
        bfc_pkg::t_plane planes[bfc_pkg::NUM_PLANES];
        t_vis_entry      vis_pending[$];
        int              mismatches;
        int              n_visible;
        int              n_culled;

        function new();
            mismatches = 0;
            n_visible  = 0;
            n_culled   = 0;
            foreach (planes[i]) planes[i] = '0;
        endfunction

        // spare indexes are ignored, as in the block
        function void set_plane(int idx, bfc_pkg::t_plane value);
            if (idx < bfc_pkg::NUM_PLANES) begin
                planes[idx] = value;
            end
        endfunction

        // culled when some plane has all eight corners strictly negative
        function bit box_visible(t_box b);
            longint cx, cy, cz, hx, hy, hz;
            longint ca, cb, cc, dd;
            longint x, y, z, s;
            bit     all_neg;
            bit     vis;
            cx  = $signed(b.cx);
            cy  = $signed(b.cy);
            cz  = $signed(b.cz);
            hx  = b.hx;
            hy  = b.hy;
            hz  = b.hz;
            vis = 1'b1;
            for (int p = 0; p < bfc_pkg::NUM_PLANES; p++) begin
                ca = $signed(planes[p].a);
                cb = $signed(planes[p].b);
                cc = $signed(planes[p].c);
                dd = $signed(planes[p].d);
                dd = dd <<< bfc_pkg::FRAC_BITS;
                all_neg = 1'b1;
                for (int k = 0; k < 8; k++) begin
                    x = (k & 1) ? cx + hx : cx - hx;
                    y = (k & 2) ? cy + hy : cy - hy;
                    z = (k & 4) ? cz + hz : cz - hz;
                    s = ca * x + cb * y + cc * z + dd;
                    if (s >= 0) begin
                        all_neg = 1'b0;
                    end
                end
                if (all_neg) begin
                    vis = 1'b0;
                end
            end
            return vis;
        endfunction

        function void note_box(t_box b);
            t_vis_entry e;
            e.b   = b;
            e.vis = box_visible(b);
            vis_pending.push_back(e);
        endfunction

        function void check_vis(logic got);
            t_vis_entry e;
            if (vis_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: visible=%b returned with no box pending", got);
                end
            end else begin
                e = vis_pending.pop_front();
                if (got !== e.vis) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ERROR: box c=(%0d,%0d,%0d) h=(%0d,%0d,%0d): visible exp %0b got %b",
                                 e.b.cx, e.b.cy, e.b.cz, e.b.hx, e.b.hy, e.b.hz, e.vis, got);
                    end
                end else if (e.vis) begin
                    n_visible++;
                end else begin
                    n_culled++;
                end
            end
        endfunction

        function int pending();
            return vis_pending.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [bfc_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [bfc_pkg::PLANE_W-1:0]   cfg_data;
    int                            snd_idle_pct = SND_IDLE_A;
    int                            rcv_idle_pct = RCV_IDLE_A;
    int                            hold_reqs    = 0;
    int                            plane_sets   = 0;
    int                            stall_cycles = 0;
    t_cull_scoreboard              sb = new();

    bfc_box_if #(.CoordWidth(COORD_W)) box_ch ();
    bfc_vis_if                         vis_ch ();

    box_frustum_cull_top #(
        .COORD_WIDTH (COORD_W)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_box      (box_ch),
        .o_vis      (vis_ch)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // score accepted boxes and check returned flags
    always @(posedge clk) begin
        if (rst_n) begin
            if (box_ch.valid && box_ch.ready) begin
                sb.note_box(t_box'{box_ch.center_x, box_ch.center_y, box_ch.center_z,
                                   box_ch.half_x, box_ch.half_y, box_ch.half_z});
            end
            if (vis_ch.valid && vis_ch.ready) begin
                sb.check_vis(vis_ch.visible);
            end
        end
    end

    // watchdog on cycles where no request moves
    always @(posedge clk) begin
        if (!rst_n || (box_ch.valid && box_ch.ready) || (vis_ch.valid && vis_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random back-pressure plus long hold-offs on request
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        vis_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                vis_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_reqs != hold_seen) begin
                hold_seen    = hold_reqs;
                hold_left    = HOLD_CYCLES - 1;
                vis_ch.ready <= 1'b0;
            end else begin
                vis_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    function automatic bfc_pkg::t_plane mk_plane(int a, int b, int c, int d);
        bfc_pkg::t_plane p;
        p.a = bfc_pkg::FIELD_W'(a);
        p.b = bfc_pkg::FIELD_W'(b);
        p.c = bfc_pkg::FIELD_W'(c);
        p.d = bfc_pkg::FIELD_W'(d);
        return p;
    endfunction

    function automatic t_box mk_box(int cx, int cy, int cz, int hx, int hy, int hz);
        t_box b;
        b.cx = COORD_W'(cx);
        b.cy = COORD_W'(cy);
        b.cz = COORD_W'(cz);
        b.hx = HALF_W'(hx);
        b.hy = HALF_W'(hy);
        b.hz = HALF_W'(hz);
        return b;
    endfunction

    // axis-aligned cube |x|,|y|,|z| <= r, normals pointing inward
    function automatic bfc_pkg::t_plane_set cube_frustum(int r);
        bfc_pkg::t_plane_set ps;
        ps[REG_NEAR]   = mk_plane(0, 0, Q_ONE, r);
        ps[REG_FAR]    = mk_plane(0, 0, -Q_ONE, r);
        ps[REG_LEFT]   = mk_plane(Q_ONE, 0, 0, r);
        ps[REG_RIGHT]  = mk_plane(-Q_ONE, 0, 0, r);
        ps[REG_TOP]    = mk_plane(0, -Q_ONE, 0, r);
        ps[REG_BOTTOM] = mk_plane(0, Q_ONE, 0, r);
        return ps;
    endfunction

    // mostly frustum-like planes around the origin, some raw or zero
    function automatic bfc_pkg::t_plane_set rand_planes();
        bfc_pkg::t_plane_set ps;
        int                  pick;
        for (int i = 0; i < bfc_pkg::NUM_PLANES; i++) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                ps[i] = '0;
            end else if (pick < 4) begin
                ps[i] = {$urandom, $urandom};
            end else begin
                ps[i] = mk_plane(int'($urandom_range(2 * Q_ONE)) - Q_ONE,
                                 int'($urandom_range(2 * Q_ONE)) - Q_ONE,
                                 int'($urandom_range(2 * Q_ONE)) - Q_ONE,
                                 int'($urandom_range(3000)) - 200);
            end
        end
        return ps;
    endfunction

    function automatic logic signed [COORD_W-1:0] extreme_coord();
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(3))
            0:       v = {1'b1, {HALF_W{1'b0}}};
            1:       v = {1'b0, {HALF_W{1'b1}}};
            2:       v = '0;
            default: v = '1;
        endcase
        return v;
    endfunction

    // full-range, scene-scale, extreme and near-origin boxes
    function automatic t_box rand_box();
        t_box        b;
        logic [95:0] raw;
        int          mode;
        mode = $urandom_range(99);
        if (mode < 30) begin
            raw = {$urandom, $urandom, $urandom};
            b   = raw[$bits(t_box)-1:0];
        end else if (mode < 70) begin
            b = mk_box(int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000,
                       int'($urandom_range(4000)) - 2000, $urandom_range(600),
                       $urandom_range(600), $urandom_range(600));
        end else if (mode < 85) begin
            b.cx = extreme_coord();
            b.cy = extreme_coord();
            b.cz = extreme_coord();
            b.hx = ($urandom_range(1) == 1) ? '1 : '0;
            b.hy = ($urandom_range(1) == 1) ? '1 : '0;
            b.hz = ($urandom_range(1) == 1) ? '1 : '0;
        end else begin
            b = mk_box(int'($urandom_range(400)) - 200, int'($urandom_range(400)) - 200,
                       int'($urandom_range(400)) - 200, $urandom_range(100),
                       $urandom_range(100), $urandom_range(100));
        end
        return b;
    endfunction

    // offer one box request, with random sender gaps ahead of it
    task automatic send_box(input t_box b);
        while ($urandom_range(99) < snd_idle_pct) begin
            box_ch.valid <= 1'b0;
            @(posedge clk);
        end
        box_ch.valid    <= 1'b1;
        box_ch.center_x <= b.cx;
        box_ch.center_y <= b.cy;
        box_ch.center_z <= b.cz;
        box_ch.half_x   <= b.hx;
        box_ch.half_y   <= b.hy;
        box_ch.half_z   <= b.hz;
        do begin
            @(posedge clk);
        end while (!box_ch.ready);
    endtask

    // stop offering and wait for every pending flag
    task automatic wait_drain();
        box_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) begin
            @(posedge clk);
        end
    endtask

    // write all plane registers, then junk into the spare indexes
    task automatic load_planes(input bfc_pkg::t_plane_set ps);
        logic [bfc_pkg::PLANE_W-1:0] word;
        for (int i = 0; i < (1 << bfc_pkg::CFG_IDX_W); i++) begin
            word     = (i < bfc_pkg::NUM_PLANES) ? bfc_pkg::PLANE_W'(ps[i])
                                                 : {$urandom, $urandom};
            cfg_we   <= 1'b1;
            cfg_idx  <= bfc_pkg::CFG_IDX_W'(i);
            cfg_data <= word;
            @(posedge clk);
            sb.set_plane(i, word);
        end
        cfg_we <= 1'b0;
        plane_sets++;
    endtask

    initial begin : stimulus
        bfc_pkg::t_plane_set ps;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        box_ch.valid    = 1'b0;
        box_ch.center_x = '0;
        box_ch.center_y = '0;
        box_ch.center_z = '0;
        box_ch.half_x   = '0;
        box_ch.half_y   = '0;
        box_ch.half_z   = '0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset planes are all zero and never cull
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(-32768, 32767, -32768, 0, 0, 0));

        // cube: one box outside each plane, touching boundary, straddlers
        wait_drain();
        load_planes(cube_frustum(1000));
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(0, 0, -5000, 10, 10, 10));
        send_box(mk_box(0, 0, 5000, 10, 10, 10));
        send_box(mk_box(-5000, 0, 0, 10, 10, 10));
        send_box(mk_box(5000, 0, 0, 10, 10, 10));
        send_box(mk_box(0, 5000, 0, 10, 10, 10));
        send_box(mk_box(0, -5000, 0, 10, 10, 10));
        send_box(mk_box(1500, 0, 0, 500, 0, 0));
        send_box(mk_box(1501, 0, 0, 500, 0, 0));
        send_box(mk_box(30000, 0, 0, 32767, 0, 0));
        send_box(mk_box(1200, 1200, 0, 250, 250, 250));

        // most negative plane fields everywhere
        wait_drain();
        load_planes({bfc_pkg::NUM_PLANES{mk_plane(-32768, -32768, -32768, -32768)}});
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, -32768, -32768, 0, 0, 0));

        // most positive plane fields everywhere
        wait_drain();
        load_planes({bfc_pkg::NUM_PLANES{mk_plane(32767, 32767, 32767, 32767)}});
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, -32768, -32768, 0, 0, 0));

        // zero normal with negative offset culls everything
        wait_drain();
        ps           = '0;
        ps[REG_NEAR] = mk_plane(0, 0, 0, -1);
        load_planes(ps);
        send_box(mk_box(0, 0, 0, 0, 0, 0));

        // random phases with changing planes and idling
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drain();
            if (ph == 0) begin
                ps = cube_frustum(1000);
            end else begin
                ps = rand_planes();
            end
            load_planes(ps);
            if (ph < 2) begin
                snd_idle_pct = SND_IDLE_A;
                rcv_idle_pct = RCV_IDLE_A;
            end else if (ph < 4) begin
                snd_idle_pct = RCV_IDLE_A;
                rcv_idle_pct = SND_IDLE_A;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_BOXES; n++) begin
                // long result stall while boxes keep coming
                if (n == PHASE_BOXES / 2 && (ph == 1 || ph == 5)) begin
                    hold_reqs <= hold_reqs + 1;
                end
                // sender pause until the pipe is empty
                if (n == PHASE_BOXES / 2 && ph == 4) begin
                    wait_drain();
                end
                send_box(rand_box());
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("summary: %0d boxes matched (%0d visible, %0d culled) over %0d plane sets",
                 sb.n_visible + sb.n_culled, sb.n_visible, sb.n_culled, plane_sets);
        $display("summary: three idling regimes, two long result stalls, one mid-run drain");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d flags outstanding", sb.mismatches, sb.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
